FILE: rtl/core/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg: shared types and constants of the complementary tilt filter
// Widths, register indexes, the controller state and datapath command types,
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int SQRT_STEPS = 24;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ANGLE_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z = 3'd4;

  localparam logic [15:0] BLEND_ALPHA_RST = 16'd52429;
  localparam logic [23:0] GYRO_SCALE_RST  = 24'd240003;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_SQRT_INIT, ST_SQRT, ST_CORDIC_INIT, ST_CORDIC,
    ST_ANGLE, ST_GMUL1, ST_GMUL2, ST_GMUL3, ST_GSUM, ST_BL1, ST_BL2, ST_BL3, ST_PUB
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SQ1, OP_SQ2, OP_SQRT_INIT, OP_SQRT_STEP, OP_CORDIC_INIT,
    OP_CORDIC_STEP, OP_ANGLE, OP_GMUL1, OP_GMUL2, OP_GMUL3, OP_GSUM, OP_BL1,
    OP_BL2, OP_BL3
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       axis;
    logic [CNT_W-1:0] iter;
    logic             publish;
  } dp_cmd_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837830;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/ictf_if.sv
// ----------------------------------------------------------------------------
// ictf_if: request channels of the complementary tilt filter
// Sample channel (raw IMU data and elapsed ticks) and result channel (angles).
// ----------------------------------------------------------------------------
interface ictf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [31:0]        elapsed_ticks;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  elapsed_ticks, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                elapsed_ticks, output ready);
endinterface

interface ictf_result_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] angle_x;
  logic signed [19:0] angle_y;
  logic signed [19:0] angle_z;
  logic               saturated;

  modport source (output valid, angle_x, angle_y, angle_z, saturated, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, saturated, output ready);
endinterface

FILE: rtl/core/ictf_ctrl.sv
// ----------------------------------------------------------------------------
// ictf_ctrl: sequencer of the complementary tilt filter
// Walks each axis through squares, square root, CORDIC, gyro step and blend,
// then publishes the result register.
// ----------------------------------------------------------------------------
module ictf_ctrl #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ictf_pkg::dp_cmd_t cmd
);
  import ictf_pkg::*;

  ctrl_state_t      state, state_next;
  logic [1:0]       axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             pub_ok;

  assign pub_ok = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (in_valid) state_next = ST_SQ1;
      ST_SQ1:         state_next = ST_SQ2;
      ST_SQ2:         state_next = ST_SQRT_INIT;
      ST_SQRT_INIT:   state_next = ST_SQRT;
      ST_SQRT:        if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = ST_CORDIC_INIT;
      ST_CORDIC_INIT: state_next = ST_CORDIC;
      ST_CORDIC:      if (cnt == CNT_W'(CORDIC_ITERATIONS - 1)) state_next = ST_ANGLE;
      ST_ANGLE:       state_next = ST_GMUL1;
      ST_GMUL1:       state_next = ST_GMUL2;
      ST_GMUL2:       state_next = ST_GMUL3;
      ST_GMUL3:       state_next = ST_GSUM;
      ST_GSUM:        state_next = ST_BL1;
      ST_BL1:         state_next = ST_BL2;
      ST_BL2:         state_next = ST_BL3;
      ST_BL3:         state_next = (axis == 2'd2) ? ST_PUB : ST_SQ1;
      ST_PUB:         if (pub_ok) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    cnt_next  = (state_next != state) ? '0 : cnt + 1'b1;
    axis_next = axis;
    if (state == ST_IDLE) begin
      axis_next = 2'd0;
    end else if (state == ST_BL3) begin
      axis_next = axis + 2'd1;
    end
  end

  // outputs
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.axis    = axis;
    cmd.iter    = cnt;
    cmd.publish = 1'b0;
    case (state)
      ST_IDLE:        cmd.op = in_valid ? OP_LOAD : OP_NOP;
      ST_SQ1:         cmd.op = OP_SQ1;
      ST_SQ2:         cmd.op = OP_SQ2;
      ST_SQRT_INIT:   cmd.op = OP_SQRT_INIT;
      ST_SQRT:        cmd.op = OP_SQRT_STEP;
      ST_CORDIC_INIT: cmd.op = OP_CORDIC_INIT;
      ST_CORDIC:      cmd.op = OP_CORDIC_STEP;
      ST_ANGLE:       cmd.op = OP_ANGLE;
      ST_GMUL1:       cmd.op = OP_GMUL1;
      ST_GMUL2:       cmd.op = OP_GMUL2;
      ST_GMUL3:       cmd.op = OP_GMUL3;
      ST_GSUM:        cmd.op = OP_GSUM;
      ST_BL1:         cmd.op = OP_BL1;
      ST_BL2:         cmd.op = OP_BL2;
      ST_BL3:         cmd.op = OP_BL3;
      ST_PUB: begin
        cmd.op      = OP_NOP;
        cmd.publish = pub_ok;
      end
      default:        cmd.op = OP_NOP;
    endcase
  end

  // hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 2'd0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
      if (state == ST_PUB && pub_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/ictf_datapath.sv
// ----------------------------------------------------------------------------
// ictf_datapath: arithmetic of the complementary tilt filter
// Shared registered multiplier, bit-serial square root, iterative CORDIC,
// configuration registers, stored angles and the result register.
// ----------------------------------------------------------------------------
module ictf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ictf_pkg::dp_cmd_t                  cmd,
  input  logic                               cfg_we,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ictf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [15:0]                 accel_x,
  input  logic signed [15:0]                 accel_y,
  input  logic signed [15:0]                 accel_z,
  input  logic signed [15:0]                 gyro_x,
  input  logic signed [15:0]                 gyro_y,
  input  logic signed [15:0]                 gyro_z,
  input  logic [31:0]                        elapsed_ticks,
  output logic signed [ictf_pkg::ANGLE_W-1:0] angle_x,
  output logic signed [ictf_pkg::ANGLE_W-1:0] angle_y,
  output logic signed [ictf_pkg::ANGLE_W-1:0] angle_z,
  output logic                               saturated
);
  import ictf_pkg::*;

  // configuration
  logic [15:0]        blend_alpha;
  logic [23:0]        gyro_scale;
  logic signed [15:0] gyro_off [3];

  // captured sample
  logic signed [15:0] ax, ay, az;
  logic signed [15:0] gyr [3];
  logic [31:0]        ticks;

  // working registers
  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [61:0] prod;
  logic [31:0]        sq_acc;
  logic [47:0]        rem, root, sbit;
  logic signed [27:0] cx, cy;
  logic signed [33:0] cz;
  logic               czero;
  logic signed [20:0] acc_ang;
  logic [23:0]        plo;
  logic [47:0]        phs;
  logic signed [35:0] g;
  logic signed [53:0] bacc;
  logic signed [ANGLE_W-1:0] fused [3];
  logic               sat_acc;

  // combinational helpers
  logic signed [15:0] sq_op1, sq_op2;
  logic signed [16:0] rate;
  logic [15:0]        mag;
  logic [47:0]        trial;
  logic signed [25:0] ci_x, ci_y;
  logic signed [27:0] xs, ys;
  logic signed [33:0] atan_v;
  logic [48:0]        dsum;
  logic signed [35:0] dsig;
  logic signed [53:0] bsum;
  logic signed [37:0] bv;
  logic signed [ANGLE_W-1:0] bclamp;
  logic               bsat;
  logic [16:0]        beta;

  // operand selection per axis
  always_comb begin
    case (cmd.axis)
      2'd0: begin sq_op1 = ax; sq_op2 = az; end
      2'd1: begin sq_op1 = ay; sq_op2 = az; end
      default: begin sq_op1 = ax; sq_op2 = ay; end
    endcase
    rate = 17'(gyr[cmd.axis]) - 17'(gyro_off[cmd.axis]);
    mag  = rate[16] ? 16'(-rate) : 16'(rate);
    case (cmd.axis)
      2'd0: begin ci_y = {{2{ay[15]}}, ay, 8'd0}; ci_x = {2'b00, root[23:0]}; end
      2'd1: begin ci_y = {{2{ax[15]}}, ax, 8'd0}; ci_x = {2'b00, root[23:0]}; end
      default: begin ci_y = {2'b00, root[23:0]}; ci_x = {{2{az[15]}}, az, 8'd0}; end
    endcase
    trial  = root + sbit;
    xs     = cx >>> cmd.iter;
    ys     = cy >>> cmd.iter;
    atan_v = 34'(atan_q30(5'(cmd.iter)));
    dsum   = 49'(phs) + 49'(prod[47:24]);
    dsig   = rate[16] ? -36'(dsum[48:16]) : 36'(dsum[48:16]);
    beta   = 17'd65536 - 17'(blend_alpha);
    bsum   = bacc + prod[53:0] + 54'sd32768;
    bv     = 38'(bsum >>> 16);
    bsat   = 1'b0;
    bclamp = bv[ANGLE_W-1:0];
    if (bv > 38'sd524287) begin
      bclamp = 20'sd524287;
      bsat   = 1'b1;
    end else if (bv < -38'sd524288) begin
      bclamp = -20'sd524288;
      bsat   = 1'b1;
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ1: begin mul_a = 37'(sq_op1); mul_b = 25'(sq_op1); end
      OP_SQ2: begin mul_a = 37'(sq_op2); mul_b = 25'(sq_op2); end
      OP_GMUL1: begin mul_a = {5'd0, ticks}; mul_b = {9'd0, mag}; end
      OP_GMUL2: begin mul_a = {13'd0, prod[47:24]}; mul_b = {1'b0, gyro_scale}; end
      OP_GMUL3: begin mul_a = {13'd0, plo}; mul_b = {1'b0, gyro_scale}; end
      OP_BL1: begin mul_a = 37'(g); mul_b = {9'd0, blend_alpha}; end
      OP_BL2: begin mul_a = 37'(acc_ang); mul_b = {8'd0, beta}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_alpha <= BLEND_ALPHA_RST;
      gyro_scale  <= GYRO_SCALE_RST;
      gyro_off[0] <= '0;
      gyro_off[1] <= '0;
      gyro_off[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_ALPHA:   blend_alpha <= cfg_data[15:0];
        REG_GYRO_SCALE:    gyro_scale  <= cfg_data[23:0];
        REG_GYRO_OFFSET_X: gyro_off[0] <= cfg_data[15:0];
        REG_GYRO_OFFSET_Y: gyro_off[1] <= cfg_data[15:0];
        REG_GYRO_OFFSET_Z: gyro_off[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stored angles and request flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fused[0] <= '0;
      fused[1] <= '0;
      fused[2] <= '0;
      sat_acc  <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      sat_acc <= 1'b0;
    end else if (cmd.op == OP_BL3) begin
      fused[cmd.axis] <= bclamp;
      sat_acc         <= sat_acc | bsat;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        ax     <= accel_x;
        ay     <= accel_y;
        az     <= accel_z;
        gyr[0] <= gyro_x;
        gyr[1] <= gyro_y;
        gyr[2] <= gyro_z;
        ticks  <= elapsed_ticks;
      end
      OP_SQ2: sq_acc <= prod[31:0];
      OP_SQRT_INIT: begin
        rem  <= {sq_acc + prod[31:0], 16'd0};
        root <= '0;
        sbit <= 48'd1 << 46;
      end
      OP_SQRT_STEP: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_CORDIC_INIT: begin
        czero <= (ci_x == '0) && (ci_y == '0);
        if (ci_x < 0) begin
          if (ci_y >= 0) begin
            cx <= 28'(ci_y);
            cy <= -28'(ci_x);
            cz <= 34'(atan_q30(5'd0)) <<< 1;
          end else begin
            cx <= -28'(ci_y);
            cy <= 28'(ci_x);
            cz <= -(34'(atan_q30(5'd0)) <<< 1);
          end
        end else begin
          cx <= 28'(ci_x);
          cy <= 28'(ci_y);
          cz <= '0;
        end
      end
      OP_CORDIC_STEP: begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_v;
        end
      end
      OP_ANGLE: acc_ang <= czero ? '0 : 21'((cz + 34'sd8192) >>> 14);
      OP_GMUL2: plo <= prod[23:0];
      OP_GMUL3: phs <= prod[47:0];
      OP_GSUM:  g <= 36'(fused[cmd.axis]) + dsig;
      OP_BL2:   bacc <= prod[53:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      angle_x   <= fused[0];
      angle_y   <= fused[1];
      angle_z   <= fused[2];
      saturated <= sat_acc;
    end
  end

endmodule

FILE: rtl/core/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter: gyro/accelerometer complementary tilt filter
// Fuses raw IMU samples into three Q3.16 radian angles.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one request per IMU reading (accel, gyro, elapsed 25 ns ticks),
//           taken when valid and ready are high. ready is high while the
//           sequencer is idle.
//   result: one request per sample with angle_x/y/z and the saturated flag,
//           held in an output register until the receiver takes it.
//   cfg:    write enable, register index, 24-bit data; write only while idle.
// Sequence: each axis goes through the squares, the square root (one bit per
//   cycle), the CORDIC iterations, the angle, the gyro step and the blend;
//   a new sample is taken only once the previous one has been published and
//   the sequencer is idle again.
// A stalled receiver holds the result; the next sample is accepted meanwhile
//   and its result waits in the publish state until the register frees.
// Reset clears the stored angles and loads default configuration.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ictf_sample_if.sink                     sample,
  ictf_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ictf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ictf_pkg::*;

  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  assign sample.ready = in_ready;
  assign result.valid = out_valid;

  // sequencer
  ictf_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(result.ready),
    .cmd      (cmd)
  );

  // arithmetic
  ictf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accel_x      (sample.accel_x),
    .accel_y      (sample.accel_y),
    .accel_z      (sample.accel_z),
    .gyro_x       (sample.gyro_x),
    .gyro_y       (sample.gyro_y),
    .gyro_z       (sample.gyro_z),
    .elapsed_ticks(sample.elapsed_ticks),
    .angle_x      (result.angle_x),
    .angle_y      (result.angle_y),
    .angle_z      (result.angle_z),
    .saturated    (result.saturated)
  );

endmodule
